>>> hdl/charge_session_controller_assert.svh
// ----------------------------------------------------------------------------
// Charge session controller assertion macros
// Clocked property forms shared by the session controller checks.
// ----------------------------------------------------------------------------
`ifndef CHARGE_SESSION_CONTROLLER_ASSERT_SVH
`define CHARGE_SESSION_CONTROLLER_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define CSC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("charge session check failed");

// next-cycle implication, sampled on clk, quiet during reset
`define CSC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("charge session check failed");

`endif

>>> hdl/csc_pkg.sv
// ----------------------------------------------------------------------------
// Charge session controller package
// Item types, session and sequencer codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package csc_pkg;

    typedef struct packed {
        logic        charge_enabled;
        logic        plug_connected;
        logic        pilot_timed_out;
        logic        pilot_pwm_present;
        logic        fault_event;
        logic [15:0] highest_cell_mv;
        logic [11:0] advertised_current;
        logic [31:0] now_ms;
    } tick_t;

    typedef struct packed {
        logic [2:0]  session_state;
        logic        pilot_switch;
        logic        request_valid;
        logic [13:0] request_voltage;
        logic [11:0] request_current;
        logic        request_disable;
    } result_t;

    typedef enum logic [2:0] {
        SS_IDLE     = 3'd0,
        SS_WAITING  = 3'd1,
        SS_ACTIVE   = 3'd2,
        SS_FAULT    = 3'd3,
        SS_COMPLETE = 3'd4
    } sess_t;

    typedef enum logic [1:0] {
        CT_IDLE,
        CT_CALC,
        CT_HOLD
    } ctl_state_t;

    typedef enum logic [1:0] {
        TP_IDLE,
        TP_MUL,
        TP_DIV
    } tp_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } taper_stat_t;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CELL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_CELL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_RANGE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_CUR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CHG_VOLT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TX_INTVL   = 3'd5;

    localparam logic [15:0] RST_MAX_CELL   = 16'd4200;
    localparam logic [15:0] RST_RAMP_CELL  = 16'd4100;
    localparam logic [15:0] RST_RAMP_RANGE = 16'd100;
    localparam logic [11:0] RST_MIN_CUR    = 12'd10;
    localparam logic [13:0] RST_CHG_VOLT   = 14'd0;
    localparam logic [15:0] RST_TX_INTVL   = 16'd1000;

    // taper arithmetic: 16 multiplier bits, 12 quotient bits, 28 bit product sum
    localparam int MUL_STEPS = 16;
    localparam int QUO_W     = 12;
    localparam int ACC_W     = 28;

endpackage

>>> hdl/csc_taper.sv
// ----------------------------------------------------------------------------
// Taper current unit
// Bit-serial (adv*e + min*d) / range: shift-add multiply then restoring divide.
// ----------------------------------------------------------------------------
module csc_taper
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [11:0]          adv,
    input  logic [11:0]          min_cur,
    input  logic [15:0]          e_span,
    input  logic [15:0]          d_span,
    input  logic [15:0]          range_mv,
    output csc_pkg::taper_stat_t stat,
    output logic [11:0]          quotient
);

    csc_pkg::tp_state_t state_reg, state_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        done_reg, done_next;
    logic [csc_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic [15:0] e_reg, e_next;
    logic [15:0] d_reg, d_next;
    logic [15:0] range_reg, range_next;
    logic [11:0] adv_reg, adv_next;
    logic [11:0] min_reg, min_next;

    logic [csc_pkg::ACC_W-1:0] mul_sum;
    logic [16:0] trial;
    logic        ge;
    logic [16:0] rem_new;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            csc_pkg::TP_IDLE:
            begin
                if (start)
                    state_next = csc_pkg::TP_MUL;
            end
            csc_pkg::TP_MUL:
            begin
                if (cnt_reg == 4'd0)
                    state_next = csc_pkg::TP_DIV;
            end
            csc_pkg::TP_DIV:
            begin
                if (cnt_reg == 4'd0)
                    state_next = csc_pkg::TP_IDLE;
            end
            default: state_next = csc_pkg::TP_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        stat.busy = (state_reg != csc_pkg::TP_IDLE);
        stat.done = done_reg;
        quotient  = acc_reg[csc_pkg::QUO_W-1:0];
    end

    // datapath; acc holds {remainder, pending dividend / quotient bits} while dividing
    always_comb
    begin
        mul_sum = {acc_reg[csc_pkg::ACC_W-2:0], 1'b0}
                + (e_reg[15] ? {16'd0, adv_reg} : {csc_pkg::ACC_W{1'b0}})
                + (d_reg[15] ? {16'd0, min_reg} : {csc_pkg::ACC_W{1'b0}});
        trial   = {acc_reg[csc_pkg::ACC_W-1:csc_pkg::QUO_W], acc_reg[csc_pkg::QUO_W-1]};
        ge      = (trial >= {1'b0, range_reg});
        rem_new = ge ? (trial - {1'b0, range_reg}) : trial;

        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        e_next     = e_reg;
        d_next     = d_reg;
        range_next = range_reg;
        adv_next   = adv_reg;
        min_next   = min_reg;
        done_next  = 1'b0;

        unique case (state_reg)
            csc_pkg::TP_IDLE:
            begin
                if (start)
                begin
                    acc_next   = '0;
                    cnt_next   = 4'(csc_pkg::MUL_STEPS - 1);
                    e_next     = e_span;
                    d_next     = d_span;
                    range_next = range_mv;
                    adv_next   = adv;
                    min_next   = min_cur;
                end
            end
            csc_pkg::TP_MUL:
            begin
                acc_next = mul_sum;
                e_next   = {e_reg[14:0], 1'b0};
                d_next   = {d_reg[14:0], 1'b0};
                if (cnt_reg == 4'd0)
                    cnt_next = 4'(csc_pkg::QUO_W - 1);
                else
                    cnt_next = cnt_reg - 4'd1;
            end
            csc_pkg::TP_DIV:
            begin
                // quotient fits 12 bits, so the top 16 bits start below range
                acc_next = {rem_new[15:0], acc_reg[csc_pkg::QUO_W-2:0], ge};
                cnt_next = cnt_reg - 4'd1;
                if (cnt_reg == 4'd0)
                    done_next = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= csc_pkg::TP_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        e_reg     <= e_next;
        d_reg     <= d_next;
        range_reg <= range_next;
        adv_reg   <= adv_next;
        min_reg   <= min_next;
    end

endmodule

>>> hdl/charge_session_controller.sv
// ----------------------------------------------------------------------------
// Charge session controller
// Session state machine, request pacing and serial taper current per tick.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  tick      tick_valid/tick_ready  tick (csc_pkg::tick_t)
//  res       res_valid/res_ready    res (csc_pkg::result_t)
//  cfg       cfg_valid/cfg_ready    cfg_index, cfg_data
//
//  A tick without a taper calculation moves its result item from the pending
//  register to the output register; the next tick can be accepted once it is loaded.
//  A tapered request runs 16 shift-add multiply steps and 12 restoring divide
//  steps in csc_taper before the quotient is written into the pending result.
//  One tick is in flight at a time; a result waiting in the output register
//  does not stop the next tick being accepted, but that tick's result then
//  holds tick_ready low until the output register frees. No clearing pass.
// ----------------------------------------------------------------------------
`include "charge_session_controller_assert.svh"

module charge_session_controller
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             tick_valid,
    output logic                             tick_ready,
    input  csc_pkg::tick_t                   tick,
    output logic                             res_valid,
    input  logic                             res_ready,
    output csc_pkg::result_t                 res,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [csc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [csc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // configuration
    logic [15:0] max_cell_reg;
    logic [15:0] ramp_cell_reg;
    logic [15:0] ramp_range_reg;
    logic [11:0] min_cur_reg;
    logic [13:0] chg_volt_reg;
    logic [15:0] tx_intvl_reg;

    // session state
    csc_pkg::sess_t sess_reg, sess_next;
    logic           sw_reg, sw_next;
    logic [31:0]    last_reg, last_next;

    csc_pkg::ctl_state_t ctl_reg, ctl_next;
    csc_pkg::result_t    pend_reg, pend_next;
    csc_pkg::result_t    res_reg, res_next;
    logic                res_valid_reg, res_valid_next;

    logic accept;
    logic load_out;
    logic out_free;
    logic taper_start;

    // tick evaluation
    logic           usable;
    csc_pkg::sess_t sess_eff;
    logic           rq_valid, rq_dis, rq_cur_needed;
    logic [13:0]    rq_volt;
    logic [11:0]    rq_cur;
    logic           need_taper;
    logic [31:0]    elapsed;
    logic [15:0]    over_mv;
    logic [15:0]    d_span;
    logic [15:0]    e_span;

    csc_pkg::taper_stat_t tstat;
    logic [11:0]          quotient;

    assign cfg_ready = 1'b1;
    assign accept    = tick_valid && tick_ready;
    assign out_free  = !res_valid_reg || res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_cell_reg   <= csc_pkg::RST_MAX_CELL;
            ramp_cell_reg  <= csc_pkg::RST_RAMP_CELL;
            ramp_range_reg <= csc_pkg::RST_RAMP_RANGE;
            min_cur_reg    <= csc_pkg::RST_MIN_CUR;
            chg_volt_reg   <= csc_pkg::RST_CHG_VOLT;
            tx_intvl_reg   <= csc_pkg::RST_TX_INTVL;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                csc_pkg::CFG_MAX_CELL:   max_cell_reg   <= cfg_data;
                csc_pkg::CFG_RAMP_CELL:  ramp_cell_reg  <= cfg_data;
                csc_pkg::CFG_RAMP_RANGE: ramp_range_reg <= cfg_data;
                csc_pkg::CFG_MIN_CUR:    min_cur_reg    <= cfg_data[11:0];
                csc_pkg::CFG_CHG_VOLT:   chg_volt_reg   <= cfg_data[13:0];
                csc_pkg::CFG_TX_INTVL:   tx_intvl_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        usable   = tick.plug_connected && !tick.pilot_timed_out && tick.pilot_pwm_present;
        sess_eff = tick.fault_event ? csc_pkg::SS_FAULT : sess_reg;
        elapsed  = tick.now_ms - last_reg;

        sess_next     = sess_reg;
        sw_next       = sw_reg;
        last_next     = last_reg;
        rq_valid      = 1'b0;
        rq_dis        = 1'b0;
        rq_volt       = '0;
        rq_cur_needed = 1'b0;

        if (tick.charge_enabled)
        begin
            unique case (sess_eff)
                csc_pkg::SS_IDLE:
                begin
                    sw_next   = 1'b0;
                    rq_valid  = 1'b1;
                    rq_dis    = 1'b1;
                    sess_next = usable ? csc_pkg::SS_WAITING : csc_pkg::SS_IDLE;
                end
                csc_pkg::SS_WAITING:
                begin
                    if (!usable)
                        sess_next = csc_pkg::SS_IDLE;
                    else
                    begin
                        sw_next   = 1'b1;
                        sess_next = csc_pkg::SS_ACTIVE;
                    end
                end
                csc_pkg::SS_ACTIVE:
                begin
                    sess_next = csc_pkg::SS_ACTIVE;
                    if (!usable)
                        sess_next = csc_pkg::SS_IDLE;
                    else if (tick.highest_cell_mv > max_cell_reg)
                        sess_next = csc_pkg::SS_COMPLETE;
                    else if (elapsed >= {16'd0, tx_intvl_reg})
                    begin
                        rq_valid      = 1'b1;
                        rq_volt       = chg_volt_reg;
                        rq_cur_needed = 1'b1;
                        last_next     = tick.now_ms;
                    end
                end
                default:
                begin
                    // fault and complete latch until reset
                    sess_next = sess_eff;
                    sw_next   = 1'b0;
                    rq_valid  = 1'b1;
                    rq_dis    = 1'b1;
                end
            endcase
        end
    end

    // taper operands: d = min(v - ramp, range), e = range - d
    always_comb
    begin
        over_mv    = tick.highest_cell_mv - ramp_cell_reg;
        d_span     = (over_mv > ramp_range_reg) ? ramp_range_reg : over_mv;
        e_span     = ramp_range_reg - d_span;
        need_taper = 1'b0;
        rq_cur     = '0;
        if (rq_cur_needed)
        begin
            if (tick.highest_cell_mv <= ramp_cell_reg)
                rq_cur = tick.advertised_current;
            else if (ramp_range_reg == 16'd0)
                rq_cur = min_cur_reg;
            else
                need_taper = 1'b1;
        end
    end

    csc_taper u_taper
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (taper_start),
        .adv      (tick.advertised_current),
        .min_cur  (min_cur_reg),
        .e_span   (e_span),
        .d_span   (d_span),
        .range_mv (ramp_range_reg),
        .stat     (tstat),
        .quotient (quotient)
    );

    // sequencer next state
    always_comb
    begin
        ctl_next = ctl_reg;
        unique case (ctl_reg)
            csc_pkg::CT_IDLE:
            begin
                if (accept)
                    ctl_next = need_taper ? csc_pkg::CT_CALC : csc_pkg::CT_HOLD;
            end
            csc_pkg::CT_CALC:
            begin
                if (tstat.done)
                    ctl_next = csc_pkg::CT_HOLD;
            end
            csc_pkg::CT_HOLD:
            begin
                if (out_free)
                    ctl_next = csc_pkg::CT_IDLE;
            end
            default: ctl_next = csc_pkg::CT_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        tick_ready  = (ctl_reg == csc_pkg::CT_IDLE);
        taper_start = (ctl_reg == csc_pkg::CT_IDLE) && tick_valid && need_taper;
        load_out    = (ctl_reg == csc_pkg::CT_HOLD) && out_free;
    end

    always_comb
    begin
        pend_next = pend_reg;
        if (accept)
        begin
            pend_next.session_state   = sess_next;
            pend_next.pilot_switch    = sw_next;
            pend_next.request_valid   = rq_valid;
            pend_next.request_voltage = rq_volt;
            pend_next.request_current = rq_cur;
            pend_next.request_disable = rq_dis;
        end
        else if (ctl_reg == csc_pkg::CT_CALC && tstat.done)
            pend_next.request_current = quotient;

        res_next       = load_out ? pend_reg : res_reg;
        res_valid_next = load_out || (res_valid_reg && !res_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg       <= csc_pkg::CT_IDLE;
            sess_reg      <= csc_pkg::SS_IDLE;
            sw_reg        <= 1'b0;
            last_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            ctl_reg       <= ctl_next;
            res_valid_reg <= res_valid_next;
            if (accept)
            begin
                sess_reg <= sess_next;
                sw_reg   <= sw_next;
                last_reg <= last_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        res_reg  <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    `CSC_ASSERT_SAME(a_ready_taper_idle, tick_ready, !tstat.busy)
    `CSC_ASSERT_SAME(a_done_in_calc, tstat.done, ctl_reg == csc_pkg::CT_CALC)
    `CSC_ASSERT_NEXT(a_fault_sticky, sess_reg == csc_pkg::SS_FAULT,
                     sess_reg == csc_pkg::SS_FAULT)
    `CSC_ASSERT_SAME(a_no_request_zero, res_valid && !res.request_valid,
                     res.request_current == 12'd0 && res.request_voltage == 14'd0
                     && !res.request_disable)

endmodule
